@@ rtl/core/tilt_pid_motor_drive_macros.svh @@
// Assertion helpers for the tilt PID motor drive checker.
`ifndef TILT_PID_MOTOR_DRIVE_MACROS_SVH
`define TILT_PID_MOTOR_DRIVE_MACROS_SVH

// Clocked on i_clk, quiet while i_rst_n is low.
`define TPMD_CHECK_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define TPMD_CHECK(lbl, prop) \
    `TPMD_CHECK_MSG(lbl, prop, "tpmd check failed")

`endif

@@ rtl/core/tpmd_pkg.sv @@
package tpmd_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int N_STEPS      = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int DIV_STEPS    = 17;
    localparam int CNT_MAX      = (N_STEPS > DIV_STEPS) ? N_STEPS : DIV_STEPS;
    localparam int CNT_W        = $clog2(CNT_MAX + 1);
    localparam int ITER_W       = $clog2(TABLE_LEN);

    localparam int DUTY_BITS = 10;
    localparam int DUTY_MAX  = (1 << DUTY_BITS) - 1;
    localparam int DUTY_W    = 10;
    localparam int ANGLE_W   = 17;
    localparam int GAIN_W    = 16;
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 32;

    localparam int CX_W    = 34;
    localparam int CZ_W    = 26;
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 60;
    localparam int DUTY_CMP_W = ACC_W - 24;

    localparam int ANG_LIMIT = 46080;
    localparam int SIN_LIMIT = 65536;
    localparam int DEG90     = 90 * 65536;
    localparam int DEG180    = 180 * 65536;
    localparam int CORDIC_K  = 652032875;

    localparam logic [2:0] REG_KP       = 3'd0;
    localparam logic [2:0] REG_KI       = 3'd1;
    localparam logic [2:0] REG_KD       = 3'd2;
    localparam logic [2:0] REG_GRAVITY  = 3'd3;
    localparam logic [2:0] REG_KEEP     = 3'd4;
    localparam logic [2:0] REG_TAKE     = 3'd5;
    localparam logic [2:0] REG_DUTY_MAX = 3'd6;

    localparam logic [1:0] DIR_STOP  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;

    localparam logic [2:0] MUL_KEEP_MEM = 3'd0;
    localparam logic [2:0] MUL_TAKE_RAW = 3'd1;
    localparam logic [2:0] MUL_KP_MAG   = 3'd2;
    localparam logic [2:0] MUL_KD_DERIV = 3'd3;
    localparam logic [2:0] MUL_KI_SUM   = 3'd4;
    localparam logic [2:0] MUL_G_SIN    = 3'd5;

    localparam logic [2:0] ACC_HOLD    = 3'd0;
    localparam logic [2:0] ACC_LOAD    = 3'd1;
    localparam logic [2:0] ACC_ADD     = 3'd2;
    localparam logic [2:0] ACC_LOAD_SH = 3'd3;
    localparam logic [2:0] ACC_ADD_SH  = 3'd4;

    typedef struct packed {
        logic              load;
        logic              cordic_step;
        logic              tilt_mode;
        logic              tilt_end;
        logic [2:0]        mul_sel;
        logic [2:0]        acc_op;
        logic              filt_end;
        logic              div_step;
        logic              div_end;
        logic              sin_end;
        logic              out_load;
        logic [ITER_W-1:0] iter;
    } t_dp_cmd;

    function automatic logic [21:0] atan_deg(input logic [ITER_W-1:0] i);
        logic [21:0] v;
        unique case (i)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/tilt_pid_motor_drive.sv @@
// Tilt PID motor drive with gravity feedforward.
// Input channel: i_in_valid / o_in_stall with accel_x, accel_z (signed raw
// samples) and elapsed_ms. A request is taken when valid is high and stall low.
// Output channel: o_out_valid / i_out_stall with duty, direction and the
// filtered angle in Q8.8 degrees; one result per input request.
// Config channel: i_cfg_valid / o_cfg_ready with a 3 bit register index and
// 16 bit data; o_cfg_ready is always high. Write only while the block is idle.
// One request is processed at a time, set by the two passes of the shared
// CORDIC unit and the 17 step serial divider; the next request is accepted
// on the cycle after the result is registered, so the block cannot take a
// new request before it is through with the last one.
// A result waits in the output register while i_out_stall is high; the block
// then finishes the next request and holds it until the register is free.
// Reset (synchronous, active low) restores the default gains, clears the
// filter, integral and previous error state and drops any pending result.
module tilt_pid_motor_drive (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [tpmd_pkg::SAMPLE_W-1:0] i_accel_x,
    input  logic signed [tpmd_pkg::SAMPLE_W-1:0] i_accel_z,
    input  logic [tpmd_pkg::SAMPLE_W-1:0]        i_elapsed_ms,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [tpmd_pkg::DUTY_W-1:0]          o_duty,
    output logic [1:0]                           o_direction,
    output logic signed [tpmd_pkg::ANGLE_W-1:0]  o_filtered_angle,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [2:0]                           i_cfg_index,
    input  logic [tpmd_pkg::GAIN_W-1:0]          i_cfg_data
);

    tpmd_pkg::t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    tpmd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    tpmd_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_accel_x        (i_accel_x),
        .i_accel_z        (i_accel_z),
        .i_elapsed_ms     (i_elapsed_ms),
        .o_duty           (o_duty),
        .o_direction      (o_direction),
        .o_filtered_angle (o_filtered_angle)
    );

endmodule

@@ rtl/core/tpmd_ctrl.sv @@
module tpmd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tpmd_pkg::t_dp_cmd    o_cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_TILT     = 5'd1;
    localparam logic [4:0] S_TILT_END = 5'd2;
    localparam logic [4:0] S_F_M1     = 5'd3;
    localparam logic [4:0] S_F_M2     = 5'd4;
    localparam logic [4:0] S_F_ACC    = 5'd5;
    localparam logic [4:0] S_F_END    = 5'd6;
    localparam logic [4:0] S_DIV      = 5'd7;
    localparam logic [4:0] S_DIV_END  = 5'd8;
    localparam logic [4:0] S_SIN      = 5'd9;
    localparam logic [4:0] S_SIN_END  = 5'd10;
    localparam logic [4:0] S_M_KP     = 5'd11;
    localparam logic [4:0] S_M_KD     = 5'd12;
    localparam logic [4:0] S_M_KI     = 5'd13;
    localparam logic [4:0] S_M_G      = 5'd14;
    localparam logic [4:0] S_M_LAST   = 5'd15;
    localparam logic [4:0] S_DONE     = 5'd16;

    logic [4:0]                    r_state, n_state;
    logic [tpmd_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                          r_out_valid, n_out_valid;
    logic                          out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.iter  = r_cnt[tpmd_pkg::ITER_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_TILT;
                end
            end
            S_TILT: begin
                o_cmd.cordic_step = 1'b1;
                o_cmd.tilt_mode   = 1'b1;
                n_cnt             = r_cnt + 1'b1;
                if (r_cnt == tpmd_pkg::CNT_W'(tpmd_pkg::N_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_TILT_END;
                end
            end
            S_TILT_END: begin
                o_cmd.tilt_end = 1'b1;
                n_state        = S_F_M1;
            end
            S_F_M1: begin
                o_cmd.mul_sel = tpmd_pkg::MUL_KEEP_MEM;
                n_state       = S_F_M2;
            end
            S_F_M2: begin
                o_cmd.mul_sel = tpmd_pkg::MUL_TAKE_RAW;
                o_cmd.acc_op  = tpmd_pkg::ACC_LOAD;
                n_state       = S_F_ACC;
            end
            S_F_ACC: begin
                o_cmd.acc_op = tpmd_pkg::ACC_ADD;
                n_state      = S_F_END;
            end
            S_F_END: begin
                o_cmd.filt_end = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == tpmd_pkg::CNT_W'(tpmd_pkg::DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DIV_END;
                end
            end
            S_DIV_END: begin
                o_cmd.div_end = 1'b1;
                n_state       = S_SIN;
            end
            S_SIN: begin
                o_cmd.cordic_step = 1'b1;
                n_cnt             = r_cnt + 1'b1;
                if (r_cnt == tpmd_pkg::CNT_W'(tpmd_pkg::N_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_SIN_END;
                end
            end
            S_SIN_END: begin
                o_cmd.sin_end = 1'b1;
                n_state       = S_M_KP;
            end
            S_M_KP: begin
                o_cmd.mul_sel = tpmd_pkg::MUL_KP_MAG;
                n_state       = S_M_KD;
            end
            S_M_KD: begin
                o_cmd.mul_sel = tpmd_pkg::MUL_KD_DERIV;
                o_cmd.acc_op  = tpmd_pkg::ACC_LOAD_SH;
                n_state       = S_M_KI;
            end
            S_M_KI: begin
                o_cmd.mul_sel = tpmd_pkg::MUL_KI_SUM;
                o_cmd.acc_op  = tpmd_pkg::ACC_ADD_SH;
                n_state       = S_M_G;
            end
            S_M_G: begin
                o_cmd.mul_sel = tpmd_pkg::MUL_G_SIN;
                o_cmd.acc_op  = tpmd_pkg::ACC_ADD_SH;
                n_state       = S_M_LAST;
            end
            S_M_LAST: begin
                o_cmd.acc_op = tpmd_pkg::ACC_ADD;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/core/tpmd_dp.sv @@
module tpmd_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tpmd_pkg::t_dp_cmd                   i_cmd,
    input  logic                                i_cfg_valid,
    input  logic [2:0]                          i_cfg_index,
    input  logic [tpmd_pkg::GAIN_W-1:0]         i_cfg_data,
    input  logic signed [tpmd_pkg::SAMPLE_W-1:0] i_accel_x,
    input  logic signed [tpmd_pkg::SAMPLE_W-1:0] i_accel_z,
    input  logic [tpmd_pkg::SAMPLE_W-1:0]       i_elapsed_ms,
    output logic [tpmd_pkg::DUTY_W-1:0]         o_duty,
    output logic [1:0]                          o_direction,
    output logic signed [tpmd_pkg::ANGLE_W-1:0] o_filtered_angle
);

    localparam int CX_W  = tpmd_pkg::CX_W;
    localparam int CZ_W  = tpmd_pkg::CZ_W;
    localparam int ACC_W = tpmd_pkg::ACC_W;
    localparam int AW    = tpmd_pkg::ANGLE_W;

    logic [15:0] r_kp, r_ki, r_kd, r_grav, r_keep, r_take;
    logic [tpmd_pkg::DUTY_W-1:0] r_dmax;

    logic signed [CX_W-1:0]   r_cx, r_cy;
    logic signed [CZ_W-1:0]   r_cz;
    logic                     r_zero;
    logic signed [AW-1:0]     r_raw, r_mem, r_prev;
    logic signed [tpmd_pkg::SUM_W-1:0] r_esum;
    logic [AW-1:0]            r_mag;
    logic [1:0]               r_dir;
    logic [15:0]              r_ms, r_rem;
    logic [AW-1:0]            r_quo;
    logic                     r_neg;
    logic signed [AW:0]       r_deriv, r_sin;
    logic signed [tpmd_pkg::PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [tpmd_pkg::DUTY_W-1:0] r_duty;
    logic [1:0]               r_odir;
    logic signed [AW-1:0]     r_oangle;

    // CORDIC
    logic signed [CX_W-1:0]   x0, y0, sh_x, sh_y;
    logic signed [CZ_W-1:0]   ang_step, tilt_rnd, sin_z, sin_zf;
    logic                     rot_pos;
    logic signed [CX_W-1:0]   sin_rnd;
    logic signed [AW-1:0]     raw_c, f_c;
    logic signed [ACC_W-1:0]  f_rnd;
    logic signed [AW:0]       diff, sin_c;
    logic signed [tpmd_pkg::SUM_W:0] esum_w;
    logic signed [tpmd_pkg::SUM_W-1:0] esum_c;
    logic [AW-1:0]            diff_mag;
    logic [AW-1:0]            div_sh;
    logic                     div_ge;
    logic signed [tpmd_pkg::MUL_A_W-1:0] mul_a;
    logic signed [tpmd_pkg::MUL_B_W-1:0] mul_b;
    logic signed [ACC_W-1:0]  prod_x;
    logic [ACC_W-1:0]         acc_abs;
    logic [tpmd_pkg::DUTY_CMP_W-1:0] duty_raw, duty_lim;

    assign x0 = {{(CX_W-30){i_accel_z[15]}}, i_accel_z, 14'b0};
    assign y0 = {{(CX_W-30){i_accel_x[15]}}, i_accel_x, 14'b0};

    assign sh_x     = r_cx >>> i_cmd.iter;
    assign sh_y     = r_cy >>> i_cmd.iter;
    assign ang_step = CZ_W'(signed'({1'b0, tpmd_pkg::atan_deg(i_cmd.iter)}));
    assign rot_pos  = i_cmd.tilt_mode ? !r_cy[CX_W-1] : r_cz[CZ_W-1];

    assign tilt_rnd = (r_cz + CZ_W'(128)) >>> 8;
    always_comb begin
        if (r_zero)
            raw_c = '0;
        else if (tilt_rnd > CZ_W'(tpmd_pkg::ANG_LIMIT))
            raw_c = AW'(tpmd_pkg::ANG_LIMIT);
        else if (tilt_rnd < -CZ_W'(tpmd_pkg::ANG_LIMIT))
            raw_c = -AW'(tpmd_pkg::ANG_LIMIT);
        else
            raw_c = tilt_rnd[AW-1:0];
    end

    assign f_rnd = (r_acc + ACC_W'(32768)) >>> 16;
    always_comb begin
        if (f_rnd > ACC_W'(tpmd_pkg::ANG_LIMIT))
            f_c = AW'(tpmd_pkg::ANG_LIMIT);
        else if (f_rnd < -ACC_W'(tpmd_pkg::ANG_LIMIT))
            f_c = -AW'(tpmd_pkg::ANG_LIMIT);
        else
            f_c = f_rnd[AW-1:0];
    end

    assign diff     = (AW+1)'(f_c) - (AW+1)'(r_prev);
    assign diff_mag = diff[AW] ? AW'(-diff) : diff[AW-1:0];
    assign esum_w   = (tpmd_pkg::SUM_W+1)'(r_esum) + (tpmd_pkg::SUM_W+1)'(f_c);
    always_comb begin
        if (esum_w[tpmd_pkg::SUM_W] != esum_w[tpmd_pkg::SUM_W-1])
            esum_c = esum_w[tpmd_pkg::SUM_W] ? {1'b1, {(tpmd_pkg::SUM_W-1){1'b0}}}
                                              : {1'b0, {(tpmd_pkg::SUM_W-1){1'b1}}};
        else
            esum_c = esum_w[tpmd_pkg::SUM_W-1:0];
    end

    assign sin_z = {f_c[AW-1], f_c, 8'b0};
    always_comb begin
        if (sin_z > CZ_W'(tpmd_pkg::DEG90))
            sin_zf = CZ_W'(tpmd_pkg::DEG180) - sin_z;
        else if (sin_z < -CZ_W'(tpmd_pkg::DEG90))
            sin_zf = -CZ_W'(tpmd_pkg::DEG180) - sin_z;
        else
            sin_zf = sin_z;
    end

    assign sin_rnd = (r_cy + CX_W'(8192)) >>> 14;
    always_comb begin
        if (sin_rnd > CX_W'(tpmd_pkg::SIN_LIMIT))
            sin_c = (AW+1)'(tpmd_pkg::SIN_LIMIT);
        else if (sin_rnd < -CX_W'(tpmd_pkg::SIN_LIMIT))
            sin_c = -(AW+1)'(tpmd_pkg::SIN_LIMIT);
        else
            sin_c = sin_rnd[AW:0];
    end

    assign div_sh = {r_rem, r_quo[AW-1]};
    assign div_ge = div_sh >= {1'b0, r_ms};

    always_comb begin
        case (i_cmd.mul_sel)
            tpmd_pkg::MUL_KEEP_MEM: begin
                mul_a = {1'b0, r_keep};
                mul_b = tpmd_pkg::MUL_B_W'(r_mem);
            end
            tpmd_pkg::MUL_TAKE_RAW: begin
                mul_a = {1'b0, r_take};
                mul_b = tpmd_pkg::MUL_B_W'(r_raw);
            end
            tpmd_pkg::MUL_KP_MAG: begin
                mul_a = {1'b0, r_kp};
                mul_b = {{(tpmd_pkg::MUL_B_W-AW){1'b0}}, r_mag};
            end
            tpmd_pkg::MUL_KD_DERIV: begin
                mul_a = {1'b0, r_kd};
                mul_b = tpmd_pkg::MUL_B_W'(r_deriv);
            end
            tpmd_pkg::MUL_KI_SUM: begin
                mul_a = {1'b0, r_ki};
                mul_b = tpmd_pkg::MUL_B_W'(r_esum);
            end
            default: begin
                mul_a = {1'b0, r_grav};
                mul_b = tpmd_pkg::MUL_B_W'(r_sin);
            end
        endcase
    end

    assign prod_x   = ACC_W'(r_prod);
    assign acc_abs  = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign duty_raw = acc_abs[ACC_W-1:24];
    assign duty_lim = (tpmd_pkg::DUTY_CMP_W'(r_dmax) < tpmd_pkg::DUTY_CMP_W'(tpmd_pkg::DUTY_MAX))
                    ? tpmd_pkg::DUTY_CMP_W'(r_dmax)
                    : tpmd_pkg::DUTY_CMP_W'(tpmd_pkg::DUTY_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= '0;
            r_ki   <= '0;
            r_kd   <= '0;
            r_grav <= 16'd247;
            r_keep <= 16'd59415;
            r_take <= 16'd6119;
            r_dmax <= tpmd_pkg::DUTY_W'(1023);
            r_mem  <= '0;
            r_prev <= '0;
            r_esum <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tpmd_pkg::REG_KP:       r_kp   <= i_cfg_data;
                    tpmd_pkg::REG_KI:       r_ki   <= i_cfg_data;
                    tpmd_pkg::REG_KD:       r_kd   <= i_cfg_data;
                    tpmd_pkg::REG_GRAVITY:  r_grav <= i_cfg_data;
                    tpmd_pkg::REG_KEEP:     r_keep <= i_cfg_data;
                    tpmd_pkg::REG_TAKE:     r_take <= i_cfg_data;
                    tpmd_pkg::REG_DUTY_MAX: r_dmax <= i_cfg_data[tpmd_pkg::DUTY_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.filt_end) begin
                r_mem  <= f_c;
                r_prev <= f_c;
                r_esum <= esum_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        case (i_cmd.acc_op)
            tpmd_pkg::ACC_LOAD:    r_acc <= prod_x;
            tpmd_pkg::ACC_ADD:     r_acc <= r_acc + prod_x;
            tpmd_pkg::ACC_LOAD_SH: r_acc <= prod_x <<< 8;
            tpmd_pkg::ACC_ADD_SH:  r_acc <= r_acc + (prod_x <<< 8);
            default: ;
        endcase

        if (i_cmd.load) begin
            r_zero <= (i_accel_x == '0) && (i_accel_z == '0);
            r_ms   <= i_elapsed_ms;
            if (x0[CX_W-1]) begin
                if (!y0[CX_W-1]) begin
                    r_cx <= y0;
                    r_cy <= -x0;
                    r_cz <= CZ_W'(tpmd_pkg::DEG90);
                end else begin
                    r_cx <= -y0;
                    r_cy <= x0;
                    r_cz <= -CZ_W'(tpmd_pkg::DEG90);
                end
            end else begin
                r_cx <= x0;
                r_cy <= y0;
                r_cz <= '0;
            end
        end else if (i_cmd.cordic_step) begin
            if (rot_pos) begin
                r_cx <= r_cx + sh_y;
                r_cy <= r_cy - sh_x;
                r_cz <= r_cz + ang_step;
            end else begin
                r_cx <= r_cx - sh_y;
                r_cy <= r_cy + sh_x;
                r_cz <= r_cz - ang_step;
            end
        end else if (i_cmd.filt_end) begin
            r_cx <= CX_W'(tpmd_pkg::CORDIC_K);
            r_cy <= '0;
            r_cz <= sin_zf;
        end

        if (i_cmd.tilt_end)
            r_raw <= raw_c;

        if (i_cmd.filt_end) begin
            r_mag <= f_c[AW-1] ? AW'(-f_c) : f_c;
            r_dir <= (f_c == '0) ? tpmd_pkg::DIR_STOP
                   : (f_c[AW-1] ? tpmd_pkg::DIR_LEFT : tpmd_pkg::DIR_RIGHT);
            r_quo <= diff_mag;
            r_rem <= '0;
            r_neg <= diff[AW];
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? 16'(div_sh - {1'b0, r_ms}) : div_sh[15:0];
            r_quo <= {r_quo[AW-2:0], div_ge};
        end

        if (i_cmd.div_end) begin
            if (r_ms == '0)
                r_deriv <= '0;
            else
                r_deriv <= r_neg ? -(AW+1)'(r_quo) : (AW+1)'(r_quo);
        end

        if (i_cmd.sin_end)
            r_sin <= sin_c;

        if (i_cmd.out_load) begin
            r_duty   <= (duty_raw > duty_lim) ? duty_lim[tpmd_pkg::DUTY_W-1:0]
                                              : duty_raw[tpmd_pkg::DUTY_W-1:0];
            r_odir   <= r_dir;
            r_oangle <= r_mem;
        end
    end

    assign o_duty           = r_duty;
    assign o_direction      = r_odir;
    assign o_filtered_angle = r_oangle;

endmodule

@@ rtl/core/tpmd_chk.sv @@
`include "tilt_pid_motor_drive_macros.svh"

module tpmd_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic [tpmd_pkg::DUTY_W-1:0]          o_duty,
    input logic [1:0]                           o_direction,
    input logic signed [tpmd_pkg::ANGLE_W-1:0]  o_filtered_angle
);

    // hold a stalled result
    `TPMD_CHECK(a_out_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_duty) && $stable(o_direction) && $stable(o_filtered_angle)))

    `TPMD_CHECK_MSG(a_busy_after_accept, (i_in_valid && !o_in_stall) |=> o_in_stall, "not busy after an accepted request")

    `TPMD_CHECK(a_stop_zero, o_out_valid |-> ((o_direction == tpmd_pkg::DIR_STOP) == (o_filtered_angle == '0)))

    `TPMD_CHECK(a_left_neg, o_out_valid |-> ((o_direction == tpmd_pkg::DIR_LEFT) == o_filtered_angle[tpmd_pkg::ANGLE_W-1]))

endmodule

bind tilt_pid_motor_drive tpmd_chk u_tpmd_chk (.*);

@@ tb/tb_top.sv @@
module tb_top;

    typedef struct packed {
        logic signed [tpmd_pkg::SAMPLE_W-1:0] ax;
        logic signed [tpmd_pkg::SAMPLE_W-1:0] az;
        logic [tpmd_pkg::SAMPLE_W-1:0]        ms;
    } t_sample;

    typedef struct packed {
        logic [tpmd_pkg::DUTY_W-1:0]         duty;
        logic [1:0]                          dir;
        logic signed [tpmd_pkg::ANGLE_W-1:0] angle;
    } t_drive;

    localparam longint ARCTAN_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };
    localparam int STALL_LIMIT = 5000;

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  i_in_valid;
    logic                                  o_in_stall;
    logic signed [tpmd_pkg::SAMPLE_W-1:0]  i_accel_x;
    logic signed [tpmd_pkg::SAMPLE_W-1:0]  i_accel_z;
    logic [tpmd_pkg::SAMPLE_W-1:0]         i_elapsed_ms;
    logic                                  o_out_valid;
    logic                                  i_out_stall;
    logic [tpmd_pkg::DUTY_W-1:0]           o_duty;
    logic [1:0]                            o_direction;
    logic signed [tpmd_pkg::ANGLE_W-1:0]   o_filtered_angle;
    logic                                  i_cfg_valid;
    logic                                  o_cfg_ready;
    logic [2:0]                            i_cfg_index;
    logic [tpmd_pkg::GAIN_W-1:0]           i_cfg_data;

    tilt_pid_motor_drive u_top (.*);

    t_sample pending_samples[$];
    t_drive  drive_expected[$];
    int      sender_idle_pct;
    int      receiver_stall_pct;
    int      mismatch_count;
    int      quiet_cycles;

    longint kp, ki, kd, grav, keep, take, dmax;
    longint angle_mem, prev_err, err_sum;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint raw_tilt(longint ax, longint az);
        longint x, y, z, t, dx, dy;
        x = az * 16384;
        y = ax * 16384;
        z = 0;
        if (ax == 0 && az == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = tpmd_pkg::DEG90;
            end else begin
                x = -y;
                y = t;
                z = -tpmd_pkg::DEG90;
            end
        end
        for (int i = 0; i < tpmd_pkg::N_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx;
                y -= dy;
                z += ARCTAN_Q16[i];
            end else begin
                x -= dx;
                y += dy;
                z -= ARCTAN_Q16[i];
            end
        end
        z = (z + 128) >>> 8;
        return z > tpmd_pkg::ANG_LIMIT ? tpmd_pkg::ANG_LIMIT
             : (z < -tpmd_pkg::ANG_LIMIT ? -tpmd_pkg::ANG_LIMIT : z);
    endfunction

    function automatic longint sine_q16(longint ang);
        longint x, y, z, dx, dy;
        z = ang * 256;
        x = tpmd_pkg::CORDIC_K;
        y = 0;
        if (z > tpmd_pkg::DEG90) z = tpmd_pkg::DEG180 - z;
        else if (z < -tpmd_pkg::DEG90) z = -tpmd_pkg::DEG180 - z;
        for (int i = 0; i < tpmd_pkg::N_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= ARCTAN_Q16[i];
            end else begin
                x += dx;
                y -= dy;
                z += ARCTAN_Q16[i];
            end
        end
        y = (y + 8192) >>> 14;
        return y > tpmd_pkg::SIN_LIMIT ? tpmd_pkg::SIN_LIMIT
             : (y < -tpmd_pkg::SIN_LIMIT ? -tpmd_pkg::SIN_LIMIT : y);
    endfunction

    function automatic t_drive predict_drive(t_sample s);
        longint f, diff, deriv, mag, total, duty, lim;
        t_drive r;
        f = keep * angle_mem + take * raw_tilt(s.ax, s.az);
        f = (f + 32768) >>> 16;
        f = f > tpmd_pkg::ANG_LIMIT ? tpmd_pkg::ANG_LIMIT
          : (f < -tpmd_pkg::ANG_LIMIT ? -tpmd_pkg::ANG_LIMIT : f);
        angle_mem = f;
        diff = f - prev_err;
        deriv = (s.ms == 0) ? 0 : diff / longint'(s.ms);
        err_sum = err_sum + f;
        if (err_sum > 64'sd2147483647) err_sum = 64'sd2147483647;
        if (err_sum < -64'sd2147483648) err_sum = -64'sd2147483648;
        prev_err = f;
        mag = f < 0 ? -f : f;
        total = (kp * mag + kd * deriv + ki * err_sum) * 256 + grav * sine_q16(f);
        if (total < 0) total = -total;
        duty = total >>> 24;
        lim = (dmax < tpmd_pkg::DUTY_MAX) ? dmax : tpmd_pkg::DUTY_MAX;
        if (duty > lim) duty = lim;
        r.duty = duty[tpmd_pkg::DUTY_W-1:0];
        r.dir = (f == 0) ? tpmd_pkg::DIR_STOP
              : (f > 0 ? tpmd_pkg::DIR_RIGHT : tpmd_pkg::DIR_LEFT);
        r.angle = f[tpmd_pkg::ANGLE_W-1:0];
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                drive_expected.push_back(predict_drive({i_accel_x, i_accel_z, i_elapsed_ms}));
            if (!i_in_valid || !o_in_stall) begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    t_sample s;
                    s = pending_samples.pop_front();
                    i_accel_x <= s.ax;
                    i_accel_z <= s.az;
                    i_elapsed_ms <= s.ms;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (drive_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result duty=%0d dir=%0d angle=%0d",
                             o_duty, o_direction, o_filtered_angle);
            end else begin
                t_drive e;
                e = drive_expected.pop_front();
                if (e.duty !== o_duty || e.dir !== o_direction
                    || e.angle !== o_filtered_angle) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected duty=%0d dir=%0d angle=%0d, got %0d %0d %0d",
                                 e.duty, e.dir, e.angle,
                                 o_duty, o_direction, o_filtered_angle);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("** tilt_pid_motor_drive: FAILED **");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [tpmd_pkg::GAIN_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            tpmd_pkg::REG_KP:       kp = longint'(data);
            tpmd_pkg::REG_KI:       ki = longint'(data);
            tpmd_pkg::REG_KD:       kd = longint'(data);
            tpmd_pkg::REG_GRAVITY:  grav = longint'(data);
            tpmd_pkg::REG_KEEP:     keep = longint'(data);
            tpmd_pkg::REG_TAKE:     take = longint'(data);
            tpmd_pkg::REG_DUTY_MAX: dmax = longint'(data[tpmd_pkg::DUTY_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic write_all(int g0, int g1, int g2, int g3, int g4, int g5, int g6);
        write_reg(tpmd_pkg::REG_KP, tpmd_pkg::GAIN_W'(g0));
        write_reg(tpmd_pkg::REG_KI, tpmd_pkg::GAIN_W'(g1));
        write_reg(tpmd_pkg::REG_KD, tpmd_pkg::GAIN_W'(g2));
        write_reg(tpmd_pkg::REG_GRAVITY, tpmd_pkg::GAIN_W'(g3));
        write_reg(tpmd_pkg::REG_KEEP, tpmd_pkg::GAIN_W'(g4));
        write_reg(tpmd_pkg::REG_TAKE, tpmd_pkg::GAIN_W'(g5));
        write_reg(tpmd_pkg::REG_DUTY_MAX, tpmd_pkg::GAIN_W'(g6));
    endtask

    task automatic push_sample(int ax, int az, int ms);
        t_sample s;
        s.ax = tpmd_pkg::SAMPLE_W'(ax);
        s.az = tpmd_pkg::SAMPLE_W'(az);
        s.ms = tpmd_pkg::SAMPLE_W'(ms);
        pending_samples.push_back(s);
    endtask

    task automatic push_random(int n);
        int mode;
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(9);
            if (mode < 5)
                push_sample($urandom_range(8000) - 4000, $urandom_range(20000),
                            $urandom_range(20));
            else if (mode < 8)
                push_sample($urandom, $urandom, $urandom_range(3));
            else
                push_sample($urandom, $urandom, $urandom);
        end
    endtask

    task automatic drain;
        do @(posedge i_clk);
        while (pending_samples.size() != 0 || i_in_valid || drive_expected.size() != 0);
        repeat (70) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_accel_x = '0;
        i_accel_z = '0;
        i_elapsed_ms = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        mismatch_count = 0;
        quiet_cycles = 0;
        kp = 0; ki = 0; kd = 0; grav = 247; keep = 59415; take = 6119; dmax = 1023;
        angle_mem = 0; prev_err = 0; err_sum = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_sample(0, 0, 0);
        push_sample(32767, 0, 1);
        push_sample(-32768, 0, 65535);
        push_sample(0, 32767, 0);
        push_sample(0, -32768, 5);
        push_sample(32767, -32768, 1);
        push_sample(-32768, -32768, 2);
        push_sample(-32768, 32767, 0);
        push_sample(1, -1, 1);
        push_sample(-1, -1, 1);
        drain();

        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'hFFFF);
        write_reg(3'd7, 16'h1234);
        push_sample(32767, -32768, 0);
        for (int i = 0; i < 6; i++) push_sample(32767, 100, 1);
        for (int i = 0; i < 6; i++) push_sample(-32768, 100, 65535);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_all(0, 0, 0, 0, 0, 0, 0);
                1: write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: write_all(300, 2, 40, 247, 59415, 6119, 500);
                3: write_all($urandom, $urandom_range(8), $urandom, $urandom,
                             $urandom_range(65535), $urandom, $urandom);
                default: write_all(1200, 5, 800, 512, 30000, 35535, 1023);
            endcase
            sender_idle_pct = (ph == 1) ? 52 : (ph == 3 ? 9 : 0);
            receiver_stall_pct = (ph == 2) ? 52 : (ph == 3 ? 9 : 0);
            push_random(120);
            drain();
        end

        if (mismatch_count == 0)
            $display("** tilt_pid_motor_drive: PASSED **");
        else
            $display("** tilt_pid_motor_drive: FAILED **");
        $finish;
    end
endmodule
